/* src/cst_pkg.sv */
// Types and constants shared by the client slot table modules.
package cst_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int ENT_W = 5;
  localparam logic [31:0] TIMEOUT_RESET = 32'd15000;

  localparam logic [1:0] REQ_CONNECT = 2'd0;
  localparam logic [1:0] REQ_ACTIVITY = 2'd1;
  localparam logic [1:0] REQ_DISCONNECT = 2'd2;
  localparam logic [1:0] REQ_TICK = 2'd3;

  localparam logic [1:0] STATUS_DONE = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_NOT_CONNECTED = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] client_ip;
    logic [2:0]  client_index;
    logic [31:0] now_ms;
  } cst_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] entry_index;
    logic       slot_found;
    logic [2:0] slot_index;
    logic [7:0] closed_mask;
  } cst_res_t;

  typedef struct packed {
    logic                   valid;
    cst_req_t               req;
    logic                   free_found;
    logic [ENT_W-1:0]       free_idx;
    logic                   match_found;
    logic                   match_has;
    logic [ENT_W-1:0]       match_slot;
    logic [MAX_ENTRIES-1:0] used;
    logic                   hit;
    logic [7:0]             mask;
  } cst_tok_t;

  typedef struct packed {
    logic             en;
    logic [ENT_W-1:0] idx;
    logic [31:0]      ip;
    logic [31:0]      now_ms;
    logic             has_slot;
    logic [ENT_W-1:0] slot;
  } cst_wr_t;

endpackage

/* src/cst_cell.sv */
// One table entry: holds its state, works on the passing request and hands it on.
module cst_cell
  import cst_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] timeout,
  input  cst_wr_t     wr,
  input  cst_tok_t    tok_in,
  output cst_tok_t    tok_out
);

  localparam logic [ENT_W-1:0] MY_IDX = ENT_W'(IDX);

  logic             connected;
  logic [31:0]      address;
  logic             has_slot;
  logic [ENT_W-1:0] slot;
  logic [31:0]      last_time;

  cst_tok_t    tok_next;
  logic        addressed;
  logic        expired;
  logic        do_clear;
  logic        do_touch;
  logic [31:0] age;

  always_comb begin
    tok_next = tok_in;
    addressed = ({2'b00, tok_in.req.client_index} == MY_IDX) && connected;
    age = tok_in.req.now_ms - last_time;
    expired = connected && (age > timeout);
    do_clear = 1'b0;
    do_touch = 1'b0;
    if (tok_in.valid) begin
      case (tok_in.req.req_type)
        REQ_CONNECT: begin
          if (!tok_in.free_found && !connected) begin
            tok_next.free_found = 1'b1;
            tok_next.free_idx = MY_IDX;
          end
          if (!tok_in.match_found) begin
            if (address == tok_in.req.client_ip) begin
              tok_next.match_found = 1'b1;
              tok_next.match_has = has_slot;
              tok_next.match_slot = slot;
            end else if (has_slot) begin
              tok_next.used[slot] = 1'b1;
            end
          end
        end
        REQ_ACTIVITY: begin
          if (addressed) begin
            tok_next.hit = 1'b1;
            do_touch = 1'b1;
          end
        end
        REQ_DISCONNECT: begin
          if (addressed) begin
            tok_next.hit = 1'b1;
            do_clear = 1'b1;
          end
        end
        default: begin
          if (expired) begin
            do_clear = 1'b1;
            if (IDX < 8) begin
              tok_next.mask[MY_IDX[2:0]] = 1'b1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      connected <= 1'b0;
      address <= '0;
      has_slot <= 1'b0;
      slot <= '0;
      last_time <= '0;
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
      if (wr.en && (wr.idx == MY_IDX)) begin
        connected <= 1'b1;
        address <= wr.ip;
        has_slot <= wr.has_slot;
        slot <= wr.slot;
        last_time <= wr.now_ms;
      end else if (do_clear) begin
        connected <= 1'b0;
        address <= '0;
        has_slot <= 1'b0;
        slot <= '0;
        last_time <= '0;
      end else if (do_touch) begin
        last_time <= tok_in.req.now_ms;
      end
    end
  end

endmodule

/* src/cst_finish.sv */
// End of the chain: forms the result item and the write for a connect.
module cst_finish
  import cst_pkg::*;
#(
  parameter int NUM_ENTRIES = 8
) (
  input  logic     clk,
  input  logic     rst,
  input  cst_tok_t tok,
  output cst_wr_t  wr,
  output logic     done,
  output cst_res_t result
);

  cst_res_t         res_next;
  logic             free_slot_found;
  logic [ENT_W-1:0] free_slot;
  logic             ok;
  logic [ENT_W-1:0] slot_sel;

  always_comb begin
    free_slot_found = 1'b0;
    free_slot = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if ((i < NUM_ENTRIES) && !tok.used[i] && !free_slot_found) begin
        free_slot_found = 1'b1;
        free_slot = ENT_W'(i);
      end
    end
    ok = tok.match_found ? tok.match_has : free_slot_found;
    slot_sel = tok.match_found ? tok.match_slot : free_slot;
    if (!ok) begin
      slot_sel = '0;
    end

    res_next = '0;
    wr = '0;
    wr.idx = tok.free_idx;
    wr.ip = tok.req.client_ip;
    wr.now_ms = tok.req.now_ms;
    wr.has_slot = ok;
    wr.slot = slot_sel;
    case (tok.req.req_type)
      REQ_CONNECT: begin
        if (!tok.free_found) begin
          res_next.status = STATUS_FULL;
        end else begin
          wr.en = tok.valid;
          res_next.status = STATUS_DONE;
          res_next.entry_index = tok.free_idx[2:0];
          res_next.slot_found = ok;
          res_next.slot_index = slot_sel[2:0];
        end
      end
      REQ_ACTIVITY, REQ_DISCONNECT: begin
        res_next.status = tok.hit ? STATUS_DONE : STATUS_NOT_CONNECTED;
      end
      default: begin
        res_next.status = STATUS_DONE;
        res_next.closed_mask = tok.mask;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tok.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tok.valid) begin
      result <= res_next;
    end
  end

endmodule

/* src/client_slot_table_unit.sv */
// Top level of the client slot table: a chain of entry cells and a finish stage.
//
// Usage: drive req and raise start; the item is taken at a rising edge with
// start high and busy low. Kinds: connect, activity, disconnect, timeout tick.
// The request walks the row of entry cells, one cell per cycle, so each cell
// compares its address and its age while the item passes by. A finish stage
// then picks the drive slot and writes the taken entry for a connect.
// Exactly one result item follows each request: done is high for one cycle
// with result valid, registered after the item leaves the last cell. busy
// stays high until that cycle, so a new request is taken only once the
// item before it has left the cell chain.
// The receiver cannot stall; result holds its value until the next item is done.
// The timeout register is written over cfg_valid/cfg_ready/cfg_data while
// the block is idle; cfg_ready is low while an item is in flight.
// Reset (rst, synchronous) clears every entry, sets the timeout to 15000 ms
// and drops any item in flight.
module client_slot_table_unit
  import cst_pkg::*;
#(
  parameter int NUM_ENTRIES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  cst_req_t    req,
  output logic        done,
  output cst_res_t    result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic [31:0]            timeout;
  cst_tok_t               tok_head;
  cst_tok_t               chain [0:NUM_ENTRIES];
  cst_wr_t                wr;
  logic [NUM_ENTRIES-1:0] in_flight;

  always_comb begin
    tok_head = '0;
    tok_head.valid = start && !busy;
    tok_head.req = req;
  end

  assign chain[0] = tok_head;

  for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_cell
    cst_cell #(
      .IDX(k)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .timeout(timeout),
      .wr(wr),
      .tok_in(chain[k]),
      .tok_out(chain[k+1])
    );
    assign in_flight[k] = chain[k+1].valid;
  end

  cst_finish #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_finish (
    .clk(clk),
    .rst(rst),
    .tok(chain[NUM_ENTRIES]),
    .wr(wr),
    .done(done),
    .result(result)
  );

  assign busy = |in_flight;
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout <= cfg_data;
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst) $onehot0(in_flight))
    else $error("more than one item in the cell chain");

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not enter the chain");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while an item is in flight");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe repeated");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status != 2'd3))
    else $error("undefined status code");

endmodule
